/* hw/rtl/hcbp_pkg.sv */
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int NUM_SYMBOLS  = 128;
    localparam int MAX_CODE_LEN = 32;
    localparam int VALUE_BITS   = 32;
    localparam int LEN_CAP      = (MAX_CODE_LEN < VALUE_BITS) ? MAX_CODE_LEN : VALUE_BITS;
    localparam int SYM_AW       = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int ENTRY_W      = VALUE_BITS + 6;
    localparam int COUNT_W      = 48;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  symbol;
        logic [31:0] code_value;
        logic [5:0]  code_length;
    } item_t;

    typedef struct packed {
        logic [7:0]         packed_byte;
        logic               last;
        logic [COUNT_W-1:0] total_bits;
    } result_t;

endpackage

/* hw/rtl/hcbp_ram.sv */
`timescale 1ns / 1ps

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]                 wdata,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* hw/rtl/huffman_code_bit_packer_top.sv */
`timescale 1ns / 1ps

// Huffman encoder with a loaded code table and a byte packer. A load word writes one
// symbol's code (length saturated to 32) and produces nothing; an encode word appends the
// symbol's code bits, from bit 7 down in each byte, and emits every byte that
// fills, with last set on the final one; a flush word emits the partial byte zero padded,
// if any, and clears the packer and the bit count. total_bits on each result is the count
// of code bits up to and including that byte. A word is accepted every cycle while the
// byte drain keeps up; an encode that completes k bytes (up to four) occupies the drain
// until all k have left, one byte per cycle while the receiver does not stall, and later
// words stall until then. The table sits in a single-port RAM read in the cycle of
// acceptance; reset marks every entry invalid, so no clearing pass is needed.
module huffman_code_bit_packer_top
    import hcbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic                   accept;
    logic                   in_range;
    logic [SYM_AW-1:0]      addr;
    logic [5:0]             len_sat;
    logic                   ram_en;
    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [NUM_SYMBOLS-1:0] entry_valid_reg;

    logic                   s1_valid_reg;
    logic [1:0]             s1_cmd_reg;
    logic                   s1_ok_reg;
    logic                   s1_adv;

    logic [7:0]             part_reg;
    logic [2:0]             pend_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [7:0]             part_next;
    logic [2:0]             pend_next;
    logic [COUNT_W-1:0]     count_next;

    logic [31:0]            buf_data_reg;
    logic [2:0]             buf_cnt_reg;
    logic [COUNT_W-1:0]     buf_total_reg;
    logic [31:0]            buf_data_next;
    logic [2:0]             buf_cnt_next;
    logic [COUNT_W-1:0]     buf_total_next;
    logic                   buf_move;
    logic                   buf_free;

    logic                   out_valid_reg;
    result_t                out_word_reg;

    logic [5:0]             entry_len;
    logic [31:0]            entry_code;
    logic [63:0]            code_shl;
    logic [31:0]            code_left;
    logic [39:0]            joined;
    logic [5:0]             total_n;
    logic [2:0]             full_bytes;

    assign in_range = ({1'b0, item.symbol} < 8'(NUM_SYMBOLS));
    assign addr     = SYM_AW'(item.symbol);
    assign len_sat  = (item.code_length > 6'(LEN_CAP)) ? 6'(LEN_CAP) : item.code_length;

    assign buf_move   = (buf_cnt_reg != 3'd0) && (!out_valid_reg || !result_stall);
    assign buf_free   = (buf_cnt_reg == 3'd0) || ((buf_cnt_reg == 3'd1) && buf_move);
    assign s1_adv     = s1_valid_reg && buf_free;
    assign item_stall = s1_valid_reg && !buf_free;
    assign accept     = item_valid && !item_stall;

    assign ram_we = accept && (item.command == CMD_LOAD) && in_range;
    assign ram_en = ram_we || (accept && (item.command == CMD_ENCODE) && in_range);

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (addr),
        .wdata ({item.code_value, len_sat}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        entry_len  = s1_ok_reg ? ram_rdata[5:0] : 6'd0;
        entry_code = s1_ok_reg ? ram_rdata[ENTRY_W-1:6] : 32'd0;
        code_shl   = 64'(entry_code) << (6'd32 - entry_len);
        code_left  = code_shl[31:0];
        joined     = {part_reg, 32'd0} | ({code_left, 8'd0} >> pend_reg);
        total_n    = {3'd0, pend_reg} + entry_len;
        full_bytes = total_n[5:3];
    end

    always_comb
    begin
        part_next      = part_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        buf_data_next  = buf_data_reg;
        buf_cnt_next   = buf_cnt_reg;
        buf_total_next = buf_total_reg;
        if (buf_move)
        begin
            buf_data_next  = {buf_data_reg[23:0], 8'd0};
            buf_cnt_next   = buf_cnt_reg - 3'd1;
            buf_total_next = buf_total_reg + COUNT_W'(8);
        end
        if (s1_adv)
        begin
            buf_cnt_next = 3'd0;
            unique case (s1_cmd_reg)
                CMD_ENCODE:
                begin
                    buf_data_next  = joined[39:8];
                    buf_cnt_next   = full_bytes;
                    buf_total_next = count_reg + COUNT_W'(4'd8 - {1'b0, pend_reg});
                    pend_next      = total_n[2:0];
                    count_next     = count_reg + COUNT_W'(entry_len);
                    unique case (full_bytes)
                        3'd0:    part_next = joined[39:32];
                        3'd1:    part_next = joined[31:24];
                        3'd2:    part_next = joined[23:16];
                        3'd3:    part_next = joined[15:8];
                        default: part_next = joined[7:0];
                    endcase
                end
                CMD_FLUSH:
                begin
                    buf_data_next  = {part_reg, 24'd0};
                    buf_cnt_next   = (pend_reg != 3'd0) ? 3'd1 : 3'd0;
                    buf_total_next = count_reg;
                    part_next      = 8'd0;
                    pend_next      = 3'd0;
                    count_next     = '0;
                end
                default:
                begin
                    buf_cnt_next = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
            part_reg        <= 8'd0;
            pend_reg        <= 3'd0;
            count_reg       <= '0;
            buf_cnt_reg     <= 3'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                entry_valid_reg[addr] <= 1'b1;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            part_reg    <= part_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            buf_cnt_reg <= buf_cnt_next;
            if (buf_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= item.command;
            s1_ok_reg  <= in_range && entry_valid_reg[addr];
        end
        buf_data_reg  <= buf_data_next;
        buf_total_reg <= buf_total_next;
        if (buf_move)
        begin
            out_word_reg.packed_byte <= buf_data_reg[31:24];
            out_word_reg.last        <= (buf_cnt_reg == 3'd1);
            out_word_reg.total_bits  <= buf_total_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

/* test/huffman_code_bit_packer_top_tb.sv */
`timescale 1ns / 1ps

module huffman_code_bit_packer_top_tb;
    import hcbp_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RAND_PER_PHASE = 72;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 200000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    item_t   pending_words[$];
    result_t expected_bytes[$];
    int      loaded_syms[$];

    logic [31:0]        code_bits [NUM_SYMBOLS];
    logic [5:0]         code_lens [NUM_SYMBOLS];
    logic [7:0]         acc_byte = '0;
    logic [2:0]         bit_pos = 3'd7;
    logic [COUNT_W-1:0] bit_count = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int cycles = 0;

    huffman_code_bit_packer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic item_t mk_item(input logic [1:0] cmd, input int sym = 0,
                                      input logic [31:0] val = '0, input int len = 0);
        item_t it;
        it.command     = cmd;
        it.symbol      = sym[6:0];
        it.code_value  = val;
        it.code_length = len[5:0];
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    task automatic pack_word(input item_t it);
        int          len;
        logic [31:0] code;
        result_t     outs[$];
        result_t     r;
        case (it.command)
            CMD_LOAD:
            begin
                if (it.symbol < NUM_SYMBOLS)
                begin
                    len = int'(it.code_length);
                    if (len > LEN_CAP)
                        len = LEN_CAP;
                    code_bits[it.symbol] = it.code_value;
                    code_lens[it.symbol] = len[5:0];
                end
            end
            CMD_ENCODE:
            begin
                if (it.symbol < NUM_SYMBOLS)
                begin
                    len  = int'(code_lens[it.symbol]);
                    code = code_bits[it.symbol];
                    for (int i = len - 1; i >= 0; i--)
                    begin
                        acc_byte[bit_pos] = code[i];
                        bit_count = bit_count + 1'b1;
                        if (bit_pos == 3'd0)
                        begin
                            r.packed_byte = acc_byte;
                            r.last        = 1'b0;
                            r.total_bits  = bit_count;
                            outs.push_back(r);
                            acc_byte = '0;
                            bit_pos  = 3'd7;
                        end
                        else
                            bit_pos = bit_pos - 1'b1;
                    end
                    if (outs.size() != 0)
                        outs[outs.size() - 1].last = 1'b1;
                    foreach (outs[k])
                        expected_bytes.push_back(outs[k]);
                end
            end
            CMD_FLUSH:
            begin
                if (bit_pos != 3'd7)
                begin
                    r.packed_byte = acc_byte;
                    r.last        = 1'b1;
                    r.total_bits  = bit_count;
                    expected_bytes.push_back(r);
                end
                acc_byte  = '0;
                bit_pos   = 3'd7;
                bit_count = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        foreach (code_bits[s])
        begin
            code_bits[s] = '0;
            code_lens[s] = '0;
        end
    end

    // driver: predict on acceptance, then offer the next word or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                pack_word(item);
            if (!item_valid || !item_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= pending_words.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch("unexpected word", 64'd0, 64'(result.packed_byte));
                else
                begin
                    exp_r = expected_bytes.pop_front();
                    if (result.packed_byte !== exp_r.packed_byte)
                        report_mismatch("packed_byte", 64'(exp_r.packed_byte),
                                        64'(result.packed_byte));
                    if (result.last !== exp_r.last)
                        report_mismatch("last", 64'(exp_r.last), 64'(result.last));
                    if (result.total_bits !== exp_r.total_bits)
                        report_mismatch("total_bits", 64'(exp_r.total_bits),
                                        64'(result.total_bits));
                end
            end
            result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int r;
        int sym;
        int len;
        int n;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        pending_words.push_back(mk_item(CMD_ENCODE, 5));
        pending_words.push_back(mk_item(CMD_FLUSH));
        pending_words.push_back(mk_item(CMD_UNUSED, 127, 32'hFFFF_FFFF, 63));
        pending_words.push_back(mk_item(CMD_LOAD, 0, 32'hFFFF_FFFF, 32));
        pending_words.push_back(mk_item(CMD_LOAD, 127, 32'h0000_0001, 1));
        pending_words.push_back(mk_item(CMD_LOAD, 1, 32'hA5A5_A5A5, 63));
        pending_words.push_back(mk_item(CMD_LOAD, 2, 32'h1234_5678, 0));
        pending_words.push_back(mk_item(CMD_LOAD, 3, 32'hDEAD_BEE5, 3));
        pending_words.push_back(mk_item(CMD_LOAD, 64, 32'h0000_0000, 33));
        pending_words.push_back(mk_item(CMD_ENCODE, 127));
        pending_words.push_back(mk_item(CMD_ENCODE, 0));
        pending_words.push_back(mk_item(CMD_ENCODE, 1));
        pending_words.push_back(mk_item(CMD_ENCODE, 2));
        pending_words.push_back(mk_item(CMD_ENCODE, 3));
        pending_words.push_back(mk_item(CMD_FLUSH));
        pending_words.push_back(mk_item(CMD_FLUSH));
        pending_words.push_back(mk_item(CMD_ENCODE, 64));
        pending_words.push_back(mk_item(CMD_FLUSH));
        pending_words.push_back(mk_item(CMD_LOAD, 3, 32'h0000_0000, 32));
        pending_words.push_back(mk_item(CMD_ENCODE, 127));
        pending_words.push_back(mk_item(CMD_ENCODE, 3));
        pending_words.push_back(mk_item(CMD_ENCODE, 0));
        pending_words.push_back(mk_item(CMD_FLUSH));
        loaded_syms = '{0, 127, 1, 2, 3, 64};

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            if (phase == 0)
                hold_req = hold_req + 1;
            n = 0;
            while (n < RAND_PER_PHASE)
            begin
                r = (n < 10) ? 0 : $urandom_range(99);
                if (r < 14)
                begin
                    sym = $urandom_range(127);
                    r = $urandom_range(99);
                    if (r < 3)
                        len = 0;
                    else if (r < 8)
                        len = $urandom_range(63, 33);
                    else if (r < 20)
                        len = $urandom_range(32, 13);
                    else
                        len = $urandom_range(12, 1);
                    pending_words.push_back(mk_item(CMD_LOAD, sym, $urandom(), len));
                    loaded_syms.push_back(sym);
                    n++;
                end
                else if (r < 82)
                begin
                    sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
                    pending_words.push_back(mk_item(CMD_ENCODE, sym, $urandom(),
                                                    $urandom_range(63)));
                    n++;
                end
                else if (r < 91)
                begin
                    pending_words.push_back(mk_item(CMD_FLUSH, $urandom_range(127),
                                                    $urandom(), $urandom_range(63)));
                    n++;
                end
                else if (r < 95)
                    pending_words.push_back(mk_item(CMD_UNUSED, $urandom_range(127),
                                                    $urandom(), $urandom_range(63)));
                else
                begin
                    pending_words.push_back(mk_item(CMD_ENCODE, $urandom_range(127)));
                    n++;
                end
            end
            while (pending_words.size() != 0)
                @(negedge clk);
        end

        while (pending_words.size() != 0 || item_valid || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (errors == 0 && expected_bytes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_ram.sv
hw/rtl/huffman_code_bit_packer_top.sv
test/huffman_code_bit_packer_top_tb.sv
